// ===== rtl/crc8bfc_pkg.sv =====
// Shared types, constants and the CRC-8 fold function for the CRC-8 frame builder and checker.
package crc8bfc_pkg;

    // CRC-8 polynomial x^8 + x^2 + x + 1, MSB first.
    localparam logic [7:0] CRC_POLY = 8'h07;

    // Reset value of the string probe length register.
    localparam logic [7:0] PROBE_LEN_RESET = 8'd31;

    // One item produces at most this many results.
    localparam int MAX_RESULTS = 3;
    localparam int BATCH_W     = $clog2(MAX_RESULTS + 1);

    // Result queue depth and the width of its fill count.
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_SEND_HEADER = 2'd0,
        OP_SEND_DATA   = 2'd1,
        OP_RX_START    = 2'd2,
        OP_RX_BYTE     = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        RX_PENDING    = 2'd0,
        RX_MATCH      = 2'd1,
        RX_MISMATCH   = 2'd2,
        RX_STRING_END = 2'd3
    } rx_status_t;

    typedef enum logic [1:0] {
        PHASE_IDLE = 2'd0,
        PHASE_DATA = 2'd1,
        PHASE_CRC  = 2'd2
    } rx_phase_t;

    // One input item.
    typedef struct packed {
        opcode_t     opcode;
        logic [6:0]  device_address;
        logic [7:0]  command_code;
        logic [7:0]  byte_count;
        logic [7:0]  data_byte;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        tx_valid;
        rx_status_t  rx_status;
        logic        last;
    } result_t;

    // All results caused by one item, in order from slot 0.
    typedef struct packed {
        logic [BATCH_W-1:0]                 count;
        result_t [MAX_RESULTS-1:0]          slot;
    } batch_t;

    // Fold one byte into the CRC, bit by bit, MSB first.
    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (v[7])
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            else
                v = {v[6:0], 1'b0};
        end
        return v;
    endfunction

endpackage

// ===== rtl/crc8bfc_engine.sv =====
// Frame state and the per-item CRC logic that turns one item into its batch of results.
module crc8bfc_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  crc8bfc_pkg::item_t   item,
    input  logic [7:0]           probe_len,
    output crc8bfc_pkg::batch_t  batch
);
    import crc8bfc_pkg::*;

    logic [7:0] tx_crc_reg, tx_crc_next;
    logic [7:0] tx_left_reg, tx_left_next;
    logic [7:0] rx_crc_reg, rx_crc_next;
    logic [7:0] rx_left_reg, rx_left_next;
    logic [7:0] rx_expected_reg, rx_expected_next;
    logic [7:0] rx_previous_reg, rx_previous_next;
    logic       rx_seen_any_reg, rx_seen_any_next;
    rx_phase_t  rx_phase_reg, rx_phase_next;

    logic [7:0] addr_crc;
    logic [7:0] header_crc;
    logic [7:0] tx_data_crc;
    logic [7:0] rx_data_crc;
    logic       string_end;

    // Shared CRC datapath.
    assign addr_crc    = crc8_fold(8'd0, {1'b0, item.device_address});
    assign header_crc  = crc8_fold(crc8_fold(addr_crc, item.command_code), item.byte_count);
    assign tx_data_crc = crc8_fold(tx_crc_reg, item.data_byte);
    assign rx_data_crc = crc8_fold(rx_crc_reg, item.data_byte);

    // A zero byte followed by the running CRC ends a probe-length frame early.
    assign string_end = rx_seen_any_reg && (rx_expected_reg == probe_len) &&
                        (rx_previous_reg == 8'd0) && (item.data_byte == rx_crc_reg);

    // Next state of the transmit and receive frames.
    always_comb
    begin
        tx_crc_next      = tx_crc_reg;
        tx_left_next     = tx_left_reg;
        rx_crc_next      = rx_crc_reg;
        rx_left_next     = rx_left_reg;
        rx_expected_next = rx_expected_reg;
        rx_previous_next = rx_previous_reg;
        rx_seen_any_next = rx_seen_any_reg;
        rx_phase_next    = rx_phase_reg;
        unique case (item.opcode)
            OP_SEND_HEADER:
            begin
                tx_crc_next  = header_crc;
                tx_left_next = item.byte_count;
            end
            OP_SEND_DATA:
            begin
                if (tx_left_reg != 8'd0)
                begin
                    tx_crc_next  = tx_data_crc;
                    tx_left_next = tx_left_reg - 8'd1;
                end
            end
            OP_RX_START:
            begin
                rx_crc_next      = addr_crc;
                rx_left_next     = item.byte_count;
                rx_expected_next = item.byte_count;
                rx_previous_next = 8'd0;
                rx_seen_any_next = 1'b0;
                rx_phase_next    = (item.byte_count == 8'd0) ? PHASE_IDLE : PHASE_DATA;
            end
            OP_RX_BYTE:
            begin
                unique case (rx_phase_reg)
                    PHASE_DATA:
                    begin
                        if (string_end)
                        begin
                            rx_phase_next = PHASE_IDLE;
                        end
                        else
                        begin
                            rx_crc_next      = rx_data_crc;
                            rx_previous_next = item.data_byte;
                            rx_seen_any_next = 1'b1;
                            rx_left_next     = rx_left_reg - 8'd1;
                            if (rx_left_reg == 8'd1)
                                rx_phase_next = PHASE_CRC;
                        end
                    end
                    default:
                    begin
                        rx_phase_next = PHASE_IDLE;
                    end
                endcase
            end
        endcase
    end

    // Results caused by the current item.
    always_comb
    begin
        batch.count = '0;
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            batch.slot[k] = '{tx_byte: 8'd0, tx_valid: 1'b0, rx_status: RX_PENDING,
                              last: 1'b0};
        end
        unique case (item.opcode)
            OP_SEND_HEADER:
            begin
                batch.slot[0].tx_byte  = item.command_code;
                batch.slot[0].tx_valid = 1'b1;
                batch.slot[1].tx_byte  = item.byte_count;
                batch.slot[1].tx_valid = 1'b1;
                if (item.byte_count == 8'd0)
                begin
                    batch.slot[2].tx_byte  = header_crc;
                    batch.slot[2].tx_valid = 1'b1;
                    batch.slot[2].last     = 1'b1;
                    batch.count            = BATCH_W'(3);
                end
                else
                begin
                    batch.count = BATCH_W'(2);
                end
            end
            OP_SEND_DATA:
            begin
                if (tx_left_reg != 8'd0)
                begin
                    batch.slot[0].tx_byte  = item.data_byte;
                    batch.slot[0].tx_valid = 1'b1;
                    if (tx_left_reg == 8'd1)
                    begin
                        batch.slot[1].tx_byte  = tx_data_crc;
                        batch.slot[1].tx_valid = 1'b1;
                        batch.slot[1].last     = 1'b1;
                        batch.count            = BATCH_W'(2);
                    end
                    else
                    begin
                        batch.count = BATCH_W'(1);
                    end
                end
            end
            OP_RX_START:
            begin
                if (item.byte_count == 8'd0)
                begin
                    batch.slot[0].rx_status = RX_MATCH;
                    batch.slot[0].last      = 1'b1;
                    batch.count             = BATCH_W'(1);
                end
            end
            OP_RX_BYTE:
            begin
                unique case (rx_phase_reg)
                    PHASE_DATA:
                    begin
                        if (string_end)
                        begin
                            batch.slot[0].rx_status = RX_STRING_END;
                            batch.slot[0].last      = 1'b1;
                        end
                        batch.count = BATCH_W'(1);
                    end
                    PHASE_CRC:
                    begin
                        batch.slot[0].rx_status = (item.data_byte == rx_crc_reg) ?
                                                  RX_MATCH : RX_MISMATCH;
                        batch.slot[0].last      = 1'b1;
                        batch.count             = BATCH_W'(1);
                    end
                    default:
                    begin
                        batch.count = '0;
                    end
                endcase
            end
        endcase
    end

    // Frame state registers, updated once per processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_crc_reg      <= 8'd0;
            tx_left_reg     <= 8'd0;
            rx_crc_reg      <= 8'd0;
            rx_left_reg     <= 8'd0;
            rx_expected_reg <= 8'd0;
            rx_previous_reg <= 8'd0;
            rx_seen_any_reg <= 1'b0;
            rx_phase_reg    <= PHASE_IDLE;
        end
        else if (fire)
        begin
            tx_crc_reg      <= tx_crc_next;
            tx_left_reg     <= tx_left_next;
            rx_crc_reg      <= rx_crc_next;
            rx_left_reg     <= rx_left_next;
            rx_expected_reg <= rx_expected_next;
            rx_previous_reg <= rx_previous_next;
            rx_seen_any_reg <= rx_seen_any_next;
            rx_phase_reg    <= rx_phase_next;
        end
    end

endmodule

// ===== rtl/crc8bfc_queue.sv =====
// Shift-register result queue that takes a batch of up to three results and drains one per transfer.
module crc8bfc_queue (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    input  crc8bfc_pkg::batch_t                batch,
    input  logic                               pop,
    output crc8bfc_pkg::result_t               head,
    output logic [crc8bfc_pkg::QCNT_W-1:0]     count
);
    import crc8bfc_pkg::*;

    result_t             q_reg  [QUEUE_DEPTH];
    result_t             q_next [QUEUE_DEPTH];
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic [QCNT_W-1:0]   level;
    logic [QCNT_W-1:0]   push_count;

    // Entries left after the pop, and how many come in.
    assign level      = count_reg - QCNT_W'(pop);
    assign push_count = push ? QCNT_W'(batch.count) : '0;

    // Shift toward the head on a pop, then append the new batch behind what stays.
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (pop && (i < QUEUE_DEPTH - 1))
                q_next[i] = q_reg[i + 1];
            else
                q_next[i] = q_reg[i];
            for (int k = 0; k < MAX_RESULTS; k++)
            begin
                if ((QCNT_W'(k) < push_count) && (QCNT_W'(i) == level + QCNT_W'(k)))
                    q_next[i] = batch.slot[k];
            end
        end
    end

    assign count_next = level + push_count;

    // Queue payload.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    // Fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign head  = q_reg[0];
    assign count = count_reg;

endmodule

// ===== rtl/crc8_bus_frame_builder_checker.sv =====
// Top level of the CRC-8 bus frame builder and checker.
//
//  Channel   Direction  Handshake            Payload
//  in        to block   in_valid / in_stall  opcode, device_address, command_code,
//                                            byte_count, data_byte
//  out       from block out_valid/out_stall  tx_byte, tx_valid, rx_status, last
//  cfg       to block   cfg_wr_en            cfg_wr_data (string probe length)
//
// An accepted item is held in the input register, is processed in one pass and its
// results are registered into a four-entry queue, whose head drives the output.
// An item is processed only when the queue holds at most one result, so items that make one
// result flow at one per cycle while the output does not stall, and a header (up to three
// results) holds later items back while the output drains one result per transfer.
// Reset clears the frame state, the queue and the input register; the probe length resets to 31.
// A stall on the output holds the queue head; the input stalls while its item lacks room.
module crc8_bus_frame_builder_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [6:0]  device_address,
    input  logic [7:0]  command_code,
    input  logic [7:0]  byte_count,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  tx_byte,
    output logic        tx_valid,
    output logic [1:0]  rx_status,
    output logic        last,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);
    import crc8bfc_pkg::*;

    logic [7:0]          probe_len_reg;
    item_t               in_item_reg;
    logic                in_full_reg, in_full_next;
    logic                in_accept;
    logic                room;
    logic                fire;
    logic                pop;
    batch_t              batch;
    result_t             head;
    logic [QCNT_W-1:0]   q_count;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            probe_len_reg <= PROBE_LEN_RESET;
        else if (cfg_wr_en)
            probe_len_reg <= cfg_wr_data;
    end

    // Processing needs room for a full batch in the queue.
    assign room      = (q_count <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS));
    assign fire      = in_full_reg && room;
    assign in_stall  = in_full_reg && !fire;
    assign in_accept = in_valid && !in_stall;
    assign in_full_next = in_accept ? 1'b1 : (fire ? 1'b0 : in_full_reg);

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else
            in_full_reg <= in_full_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_item_reg <= '0;
        else if (in_accept)
            in_item_reg <= '{opcode: opcode_t'(opcode), device_address: device_address,
                             command_code: command_code, byte_count: byte_count,
                             data_byte: data_byte};
    end

    crc8bfc_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (in_item_reg),
        .probe_len (probe_len_reg),
        .batch     (batch)
    );

    crc8bfc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fire),
        .batch (batch),
        .pop   (pop),
        .head  (head),
        .count (q_count)
    );

    // Output transfer.
    assign out_valid = (q_count != '0);
    assign pop       = out_valid && !out_stall;
    assign tx_byte   = head.tx_byte;
    assign tx_valid  = head.tx_valid;
    assign rx_status = head.rx_status;
    assign last      = head.last;

`ifndef SYNTHESIS
    // The queue never holds more than its depth.
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    // A processed item always found room for a full batch.
    a_fire_room: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (q_count <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS)))
        else $error("item processed without room for its results");

    // A header always adds at least two results, so the queue grows.
    a_header_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (in_item_reg.opcode == OP_SEND_HEADER)) |=>
        (q_count > $past(q_count)))
        else $error("header did not add its results");
`endif

endmodule
